>>> rtl/core/linked_list_table_engine_defines.svh
// ----------------------------------------------------------------------------
// Linked list table engine assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LINKED_LIST_TABLE_ENGINE_DEFINES_SVH
`define LINKED_LIST_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication
`define LLTBL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LLTBL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/lltbl_pkg.sv
// ----------------------------------------------------------------------------
// Linked list table engine package
// Slot geometry, operation and status codes, item types, helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lltbl_pkg;

  localparam int SLOTS = 64;
  localparam int LW    = 7;
  localparam int IW    = 6;
  localparam logic [LW-1:0] NONE = LW'(SLOTS);

  localparam logic [3:0] OP_INS_HEAD  = 4'd0;
  localparam logic [3:0] OP_INS_TAIL  = 4'd1;
  localparam logic [3:0] OP_INS_AFTER = 4'd2;
  localparam logic [3:0] OP_INS_SORT  = 4'd3;
  localparam logic [3:0] OP_DEL_HEAD  = 4'd4;
  localparam logic [3:0] OP_DEL_TAIL  = 4'd5;
  localparam logic [3:0] OP_DEL_AFTER = 4'd6;
  localparam logic [3:0] OP_DEL_VAL   = 4'd7;
  localparam logic [3:0] OP_SRCH_FWD  = 4'd8;
  localparam logic [3:0] OP_SRCH_BACK = 4'd9;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_BADSLOT  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [3:0]         operation;
    logic [6:0]         slot;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [6:0]         found_slot;
    logic signed [31:0] result_value;
    logic [6:0]         node_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_D6_RD, S_D6_DT, S_LA_RF, S_LA_DF, S_LA_DL, S_LA_W1,
    S_LA_W2, S_UN_RD, S_UN_DT, S_UN_W1, S_UN_W2, S_WK_IS, S_WK_DT
  } fsm_e_t;

  function automatic logic live(input logic [LW-1:0] s, input logic [SLOTS-1:0] used);
    return (s < NONE) && used[s[IW-1:0]];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/lltbl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lltbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/linked_list_table_engine.sv
// ----------------------------------------------------------------------------
// Linked list table engine
// Doubly linked list in node RAMs with a free list, one operation per item.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to transfer one operation; busy stays high
// until out_valid shows its single result for exactly one cycle, and the
// result cannot be held off. Sorted insert, delete by value and search walk
// the list node by node, since each step waits on the registered read of
// the link and value RAMs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "linked_list_table_engine_defines.svh"

module linked_list_table_engine
  import lltbl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire in_item_t  in_item,
  output      logic      busy,
  output      logic      out_valid,
  output      out_item_t out_item
);

  fsm_e_t state_r, state_nxt;
  logic [3:0]       op_r, op_nxt;
  logic [LW-1:0]    slot_r, slot_nxt;
  logic [31:0]      key_r, key_nxt;
  logic [LW-1:0]    head_r, head_nxt, tail_r, tail_nxt, free_r, free_nxt;
  logic [LW-1:0]    count_r, count_nxt;
  logic [SLOTS-1:0] used_r, used_nxt, nwr_r, nwr_nxt;
  logic [LW-1:0]    p_r, p_nxt, loc_r, loc_nxt, nx_r, nx_nxt, n_r, n_nxt;
  logic [LW-1:0]    fn_r, fn_nxt, guard_r, guard_nxt;
  logic [31:0]      rval_r, rval_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r;
  logic [IW-1:0]    nrd_a_r;
  logic             nrd_w_r;

  logic          v_we, n_we, pr_we;
  logic [IW-1:0] v_wa, n_wa, pr_wa, v_ra, n_ra, pr_ra;
  logic [31:0]   v_wd, v_rd;
  logic [LW-1:0] n_wd, pr_wd, n_rd, pr_rd, next_eff, link;
  logic          fin;
  logic [2:0]    fin_st;
  logic [LW-1:0] fin_slot;
  logic [31:0]   fin_rv;

  lltbl_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_val_ram (
    .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
  );
  lltbl_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_next_ram (
    .clk(clk), .we(n_we), .waddr(n_wa), .wdata(n_wd), .raddr(n_ra), .rdata(n_rd)
  );
  lltbl_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_prev_ram (
    .clk(clk), .we(pr_we), .waddr(pr_wa), .wdata(pr_wd), .raddr(pr_ra), .rdata(pr_rd)
  );

  // unwritten next entries read as the free chain
  assign next_eff = nrd_w_r ? n_rd : ({1'b0, nrd_a_r} + LW'(1));
  assign link     = (op_r == OP_SRCH_BACK) ? pr_rd : next_eff;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r; slot_nxt = slot_r; key_nxt = key_r;
    head_nxt = head_r; tail_nxt = tail_r; free_nxt = free_r; count_nxt = count_r;
    used_nxt = used_r; nwr_nxt = nwr_r;
    p_nxt = p_r; loc_nxt = loc_r; nx_nxt = nx_r; n_nxt = n_r;
    fn_nxt = fn_r; guard_nxt = guard_r; rval_nxt = rval_r;
    v_we = 1'b0; v_wa = n_r[IW-1:0]; v_wd = key_r; v_ra = p_r[IW-1:0];
    n_we = 1'b0; n_wa = n_r[IW-1:0]; n_wd = nx_r; n_ra = p_r[IW-1:0];
    pr_we = 1'b0; pr_wa = n_r[IW-1:0]; pr_wd = loc_r; pr_ra = p_r[IW-1:0];
    fin = 1'b0; fin_st = ST_OK; fin_slot = NONE; fin_rv = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_item.operation;
          slot_nxt  = in_item.slot;
          key_nxt   = in_item.value;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        guard_nxt = '0;
        state_nxt = S_IDLE;
        if (op_r <= OP_INS_SORT && free_r >= NONE) begin
          fin = 1'b1; fin_st = ST_FULL;
        end else if (op_r >= OP_DEL_HEAD && op_r <= OP_DEL_VAL && !live(head_r, used_r)) begin
          fin = 1'b1; fin_st = ST_EMPTY;
        end else begin
          unique case (op_r)
            OP_INS_HEAD: begin
              loc_nxt = NONE; state_nxt = S_LA_RF;
            end
            OP_INS_TAIL: begin
              loc_nxt = live(head_r, used_r) ? tail_r : NONE; state_nxt = S_LA_RF;
            end
            OP_INS_AFTER: begin
              if (slot_r == NONE) begin
                loc_nxt = NONE; state_nxt = S_LA_RF;
              end else if (!live(slot_r, used_r)) begin
                fin = 1'b1; fin_st = ST_BADSLOT;
              end else begin
                loc_nxt = slot_r; state_nxt = S_LA_RF;
              end
            end
            OP_INS_SORT: begin
              loc_nxt = NONE; p_nxt = head_r; state_nxt = S_WK_IS;
            end
            OP_DEL_HEAD: begin
              n_nxt = head_r; state_nxt = S_UN_RD;
            end
            OP_DEL_TAIL: begin
              n_nxt = tail_r; state_nxt = S_UN_RD;
            end
            OP_DEL_AFTER: begin
              if (slot_r == NONE) begin
                n_nxt = head_r; state_nxt = S_UN_RD;
              end else if (!live(slot_r, used_r)) begin
                fin = 1'b1; fin_st = ST_BADSLOT;
              end else begin
                state_nxt = S_D6_RD;
              end
            end
            OP_DEL_VAL, OP_SRCH_FWD: begin
              p_nxt = head_r; state_nxt = S_WK_IS;
            end
            OP_SRCH_BACK: begin
              p_nxt = tail_r; state_nxt = S_WK_IS;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_D6_RD: begin
        n_ra = slot_r[IW-1:0]; state_nxt = S_D6_DT;
      end
      S_D6_DT: begin
        if (!live(next_eff, used_r)) begin
          fin = 1'b1; fin_st = ST_BADSLOT; state_nxt = S_IDLE;
        end else begin
          n_nxt = next_eff; state_nxt = S_UN_RD;
        end
      end
      S_LA_RF: begin
        n_ra = free_r[IW-1:0]; state_nxt = S_LA_DF;
      end
      S_LA_DF: begin
        fn_nxt = next_eff;
        n_nxt  = free_r;
        if (loc_r == NONE) begin
          nx_nxt = head_r; state_nxt = S_LA_W1;
        end else begin
          n_ra = loc_r[IW-1:0]; state_nxt = S_LA_DL;
        end
      end
      S_LA_DL: begin
        nx_nxt = next_eff; state_nxt = S_LA_W1;
      end
      S_LA_W1: begin
        v_we = 1'b1; n_we = 1'b1; pr_we = 1'b1;
        nwr_nxt[n_r[IW-1:0]] = 1'b1;
        if (loc_r == NONE) head_nxt = n_r;
        state_nxt = S_LA_W2;
      end
      S_LA_W2: begin
        if (loc_r != NONE) begin
          n_we = 1'b1; n_wa = loc_r[IW-1:0]; n_wd = n_r;
        end
        if (nx_r != NONE) begin
          pr_we = 1'b1; pr_wa = nx_r[IW-1:0]; pr_wd = n_r;
        end else begin
          tail_nxt = n_r;
        end
        count_nxt = count_r + LW'(1);
        used_nxt[n_r[IW-1:0]] = 1'b1;
        free_nxt = fn_r;
        fin = 1'b1; fin_slot = n_r; state_nxt = S_IDLE;
      end
      S_UN_RD: begin
        v_ra = n_r[IW-1:0]; n_ra = n_r[IW-1:0]; pr_ra = n_r[IW-1:0];
        state_nxt = S_UN_DT;
      end
      S_UN_DT: begin
        rval_nxt = v_rd; nx_nxt = next_eff; loc_nxt = pr_rd; state_nxt = S_UN_W1;
      end
      S_UN_W1: begin
        if (loc_r != NONE) begin
          n_we = 1'b1; n_wa = loc_r[IW-1:0]; n_wd = nx_r;
        end else begin
          head_nxt = nx_r;
        end
        if (nx_r != NONE) begin
          pr_we = 1'b1; pr_wa = nx_r[IW-1:0]; pr_wd = loc_r;
        end else begin
          tail_nxt = loc_r;
        end
        state_nxt = S_UN_W2;
      end
      S_UN_W2: begin
        n_we = 1'b1; n_wd = free_r;
        nwr_nxt[n_r[IW-1:0]] = 1'b1;
        free_nxt = n_r;
        used_nxt[n_r[IW-1:0]] = 1'b0;
        if (count_r != '0) count_nxt = count_r - LW'(1);
        fin = 1'b1; fin_slot = n_r; fin_rv = rval_r; state_nxt = S_IDLE;
      end
      S_WK_IS: begin
        if (guard_r < NONE && live(p_r, used_r)) begin
          state_nxt = S_WK_DT;
        end else if (op_r == OP_INS_SORT) begin
          state_nxt = S_LA_RF;
        end else begin
          fin = 1'b1; fin_st = ST_NOTFOUND; state_nxt = S_IDLE;
        end
      end
      S_WK_DT: begin
        if (op_r == OP_INS_SORT) begin
          if ($signed(key_r) < $signed(v_rd)) begin
            state_nxt = S_LA_RF;
          end else begin
            loc_nxt = p_r; p_nxt = link; guard_nxt = guard_r + LW'(1);
            state_nxt = S_WK_IS;
          end
        end else if (v_rd == key_r) begin
          if (op_r == OP_DEL_VAL) begin
            n_nxt = p_r; state_nxt = S_UN_RD;
          end else begin
            fin = 1'b1; fin_slot = p_r; state_nxt = S_IDLE;
          end
        end else begin
          p_nxt = link; guard_nxt = guard_r + LW'(1); state_nxt = S_WK_IS;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NONE;
      tail_r      <= NONE;
      free_r      <= '0;
      count_r     <= '0;
      used_r      <= '0;
      nwr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_r      <= free_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      nwr_r       <= nwr_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    slot_r  <= slot_nxt;
    key_r   <= key_nxt;
    p_r     <= p_nxt;
    loc_r   <= loc_nxt;
    nx_r    <= nx_nxt;
    n_r     <= n_nxt;
    fn_r    <= fn_nxt;
    guard_r <= guard_nxt;
    rval_r  <= rval_nxt;
    nrd_a_r <= n_ra;
    nrd_w_r <= nwr_r[n_ra];
    if (fin) begin
      out_item_r.status       <= fin_st;
      out_item_r.found_slot   <= fin_slot;
      out_item_r.result_value <= fin_rv;
      out_item_r.node_count   <= count_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `LLTBL_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `LLTBL_ASSERT_NXT(a_single_result, out_valid_r, !out_valid_r, "result strobe held two cycles")
  `LLTBL_ASSERT_NOW(a_count_range, 1'b1, count_r <= NONE, "node count beyond slot count")
  `LLTBL_ASSERT_NOW(a_empty_head, !busy, (head_r == NONE) == (count_r == '0), "head and count disagree")
  `LLTBL_ASSERT_NOW(a_full_free, !busy && free_r >= NONE, count_r == NONE, "free list empty while not full")

endmodule

`default_nettype wire

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// Linked list table engine testbench
// Drives list operations through the start/busy command port. A scoreboard
// keeps its own array-based doubly linked list with a free list, predicts
// each result, and checks every out_valid transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import lltbl_pkg::*;

  localparam int RAND_ITEMS = 1750;
  localparam int CYCLE_LIMIT = 2000000;

  class list_scoreboard;
    logic signed [31:0] vals[SLOTS];
    int nxt[SLOTS];
    int prv[SLOTS];
    bit used[SLOTS];
    int head, tail, fhead, count;
    out_item_t pending[$];
    int errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        vals[i] = '0;
        nxt[i] = i + 1;
        prv[i] = SLOTS;
        used[i] = 0;
      end
      head = SLOTS;
      tail = SLOTS;
      fhead = 0;
      count = 0;
      errors = 0;
    endfunction

    function bit is_live(int s);
      return s >= 0 && s < SLOTS && used[s];
    endfunction

    function int link_after(int loc, logic signed [31:0] v);
      int n, nx;
      n = fhead;
      fhead = nxt[n];
      vals[n] = v;
      used[n] = 1;
      if (loc >= SLOTS) begin
        nx = head;
        head = n;
      end else begin
        nx = nxt[loc];
        nxt[loc] = n;
      end
      prv[n] = (loc >= SLOTS) ? SLOTS : loc;
      nxt[n] = nx;
      if (nx < SLOTS) prv[nx] = n;
      else tail = n;
      count++;
      return n;
    endfunction

    function void unlink(int n);
      int p, q;
      p = prv[n];
      q = nxt[n];
      if (p < SLOTS) nxt[p] = q;
      else head = q;
      if (q < SLOTS) prv[q] = p;
      else tail = p;
      nxt[n] = fhead;
      fhead = n;
      used[n] = 0;
      if (count > 0) count--;
    endfunction

    function int find(logic signed [31:0] v, bit fwd);
      int p;
      p = fwd ? head : tail;
      for (int g = 0; g < SLOTS && is_live(p); g++) begin
        if (vals[p] == v) return p;
        p = fwd ? nxt[p] : prv[p];
      end
      return SLOTS;
    endfunction

    // random live slot, or none
    function int pick_live();
      int k, p;
      if (count == 0) return SLOTS;
      k = $urandom_range(0, count);
      p = head;
      for (int i = 0; i < k && is_live(p); i++) p = nxt[p];
      return is_live(p) ? p : SLOTS;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      int s, where, victim, loc, p;
      bit full, empty;
      s = it.slot;
      where = SLOTS;
      victim = SLOTS;
      r.status = ST_OK;
      r.result_value = '0;
      full = fhead >= SLOTS;
      empty = !is_live(head);
      case (it.operation)
        OP_INS_HEAD, OP_INS_TAIL, OP_INS_AFTER, OP_INS_SORT: begin
          if (full) r.status = ST_FULL;
          else if (it.operation == OP_INS_HEAD) where = link_after(SLOTS, it.value);
          else if (it.operation == OP_INS_TAIL)
            where = link_after(empty ? SLOTS : tail, it.value);
          else if (it.operation == OP_INS_AFTER) begin
            if (s == SLOTS) where = link_after(SLOTS, it.value);
            else if (!is_live(s)) r.status = ST_BADSLOT;
            else where = link_after(s, it.value);
          end else begin
            loc = SLOTS;
            p = head;
            for (int g = 0; g < SLOTS && is_live(p); g++) begin
              if (it.value < vals[p]) break;
              loc = p;
              p = nxt[p];
            end
            where = link_after(loc, it.value);
          end
        end
        OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_AFTER, OP_DEL_VAL: begin
          if (empty) r.status = ST_EMPTY;
          else if (it.operation == OP_DEL_HEAD) victim = head;
          else if (it.operation == OP_DEL_TAIL) victim = tail;
          else if (it.operation == OP_DEL_AFTER) begin
            if (s == SLOTS) victim = head;
            else if (!is_live(s) || !is_live(nxt[s])) r.status = ST_BADSLOT;
            else victim = nxt[s];
          end else begin
            victim = find(it.value, 1);
            if (victim >= SLOTS) r.status = ST_NOTFOUND;
          end
          if (r.status == ST_OK && is_live(victim)) begin
            r.result_value = vals[victim];
            where = victim;
            unlink(victim);
          end
        end
        OP_SRCH_FWD, OP_SRCH_BACK: begin
          where = find(it.value, it.operation == OP_SRCH_FWD);
          if (where >= SLOTS) r.status = ST_NOTFOUND;
        end
        default: ;
      endcase
      r.found_slot = where[6:0];
      r.node_count = count[6:0];
      pending.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        report("result with no expectation");
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)
        report($sformatf("status got %0d exp %0d", got.status, e.status));
      if (got.found_slot !== e.found_slot)
        report($sformatf("found_slot got %0d exp %0d", got.found_slot, e.found_slot));
      if (got.result_value !== e.result_value)
        report($sformatf("result_value got %0d exp %0d", got.result_value,
                         e.result_value));
      if (got.node_count !== e.node_count)
        report($sformatf("node_count got %0d exp %0d", got.node_count, e.node_count));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  in_item_t  in_item;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  list_scoreboard sb;
  int cycles;
  bit no_idle;

  linked_list_table_engine u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cycles = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("linked_list_table_engine test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  task send(logic [3:0] op, int s, logic signed [31:0] v);
    in_item_t it;
    it.operation = op;
    it.slot = s[6:0];
    it.value = v;
    in_item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_input(it);
    if (!no_idle && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function logic signed [31:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 15) - 8;
    if (r < 60) return 32'sh7fffffff;
    if (r < 65) return 32'sh80000000;
    return $urandom;
  endfunction

  initial begin
    int mode, r, s;
    logic [3:0] op;
    no_idle = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list corner cases
    send(OP_DEL_HEAD, SLOTS, 0);
    send(OP_DEL_TAIL, SLOTS, 0);
    send(OP_DEL_AFTER, 3, 0);
    send(OP_DEL_VAL, SLOTS, 5);
    send(OP_SRCH_FWD, SLOTS, 5);
    send(OP_SRCH_BACK, SLOTS, 5);
    send(OP_INS_AFTER, 5, 1);
    send(OP_INS_AFTER, 127, 1);
    // building the list, then searching it, deleting from it and sending undefined opcodes
    send(OP_INS_AFTER, SLOTS, 10);
    send(OP_INS_HEAD, SLOTS, 32'sh80000000);
    send(OP_INS_TAIL, 127, 32'sh7fffffff);
    send(OP_INS_SORT, 0, 10);
    send(OP_INS_SORT, 0, -3);
    send(OP_INS_AFTER, 1, 7);
    send(OP_SRCH_FWD, 0, 10);
    send(OP_SRCH_BACK, 0, 10);
    send(OP_SRCH_FWD, 0, 99);
    send(OP_DEL_AFTER, sb.tail, 0);
    send(OP_DEL_AFTER, 100, 0);
    send(OP_DEL_AFTER, 0, 0);
    send(OP_DEL_AFTER, SLOTS, 0);
    send(OP_DEL_VAL, 0, 10);
    send(OP_DEL_VAL, 0, 1234);
    for (int k = OP_SRCH_BACK + 1; k < 16; k++) send(k[3:0], $urandom_range(0, 127), $urandom);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 150 == 0) mode = $urandom_range(0, 2);
      no_idle = (i >= 600 && i < 900);
      r = $urandom_range(0, 99);
      if (r < 3) op = 4'(OP_SRCH_BACK + $urandom_range(1, 6));
      else if ((mode == 0 && r < 75) || (mode == 1 && r < 25) || (mode == 2 && r < 50))
        op = 4'($urandom_range(OP_INS_HEAD, OP_INS_SORT));
      else if ((mode == 1 && r < 80) || (mode != 1 && r < 85))
        op = 4'($urandom_range(OP_DEL_HEAD, OP_DEL_VAL));
      else
        op = $urandom_range(0, 1) ? OP_SRCH_FWD : OP_SRCH_BACK;
      s = ($urandom_range(0, 99) < 70) ? sb.pick_live() : $urandom_range(0, 127);
      send(op, s, rand_value());
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("linked_list_table_engine test passed");
    end else begin
      $display("linked_list_table_engine test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/lltbl_pkg.sv
rtl/core/lltbl_ram.sv
rtl/core/linked_list_table_engine.sv
dv/testbench.sv
